// ----- src/pf_pkg.sv -----
// Shared types and constants for the Playfair digraph cipher core.
package pf_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE     = 5;
    localparam int CELLS    = SIDE * SIDE;
    localparam int POS_W    = 3;
    localparam int WIDE_W   = 50;
    localparam int NARROW_W = 25;
    localparam int TDATA_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X   = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;
    localparam logic [POS_W-1:0]    POS_LAST   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_TEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_FIVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd3;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [CELLS-1:0][LETTER_W-1:0] square_t;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
    } loc_t;

    typedef struct packed {
        logic    not_found;
        letter_t out_b;
        letter_t out_a;
    } pf_result_t;

endpackage

// ----- src/pf_lookup.sv -----
// Combinational Playfair transform of one prepared digraph over the key square.
module pf_lookup
    import pf_pkg::*;
(
    input  square_t    square,
    input  logic       decrypt,
    input  letter_t    letter_a,
    input  letter_t    letter_b,
    input  logic       b_present,
    output pf_result_t result
);

    // Locate the lowest-index cell holding a letter; codes above Z never match.
    function automatic loc_t find_cell(input square_t sq, input letter_t letter);
        loc_t loc;
        loc = '0;
        for (int r = SIDE - 1; r >= 0; r--)
        begin
            for (int c = SIDE - 1; c >= 0; c--)
            begin
                if (sq[r * SIDE + c] == letter)
                begin
                    loc.found = 1'b1;
                    loc.row   = POS_W'(r);
                    loc.col   = POS_W'(c);
                end
            end
        end
        if (letter > LETTER_MAX)
        begin
            loc.found = 1'b0;
        end
        return loc;
    endfunction

    function automatic logic [POS_W-1:0] wrap_step(input logic [POS_W-1:0] pos,
                                                   input logic dec);
        logic [POS_W-1:0] nxt;
        if (dec)
        begin
            nxt = (pos == '0) ? POS_LAST : pos - POS_W'(1);
        end
        else
        begin
            nxt = (pos == POS_LAST) ? '0 : pos + POS_W'(1);
        end
        return nxt;
    endfunction

    function automatic letter_t cell_at(input square_t sq, input logic [POS_W-1:0] r,
                                        input logic [POS_W-1:0] c);
        logic [LETTER_W-1:0] idx;
        idx = {r, 2'b00} + {2'b00, r} + {2'b00, c};
        return sq[idx];
    endfunction

    letter_t          a_prep;
    letter_t          b_prep;
    loc_t             loc_a;
    loc_t             loc_b;
    logic [POS_W-1:0] oa_r;
    logic [POS_W-1:0] oa_c;
    logic [POS_W-1:0] ob_r;
    logic [POS_W-1:0] ob_c;

    always_comb
    begin
        a_prep = letter_a;
        b_prep = b_present ? letter_b : LETTER_X;
        if (!decrypt)
        begin
            if (a_prep == LETTER_J)
            begin
                a_prep = LETTER_I;
            end
            if (b_prep == LETTER_J)
            begin
                b_prep = LETTER_I;
            end
            if (b_prep == a_prep)
            begin
                b_prep = LETTER_X;
            end
        end
    end

    assign loc_a = find_cell(square, a_prep);
    assign loc_b = find_cell(square, b_prep);

    always_comb
    begin
        if (loc_a.row == loc_b.row)
        begin
            // Same row, including both letters on one cell.
            oa_r = loc_a.row;
            ob_r = loc_b.row;
            oa_c = wrap_step(loc_a.col, decrypt);
            ob_c = wrap_step(loc_b.col, decrypt);
        end
        else if (loc_a.col == loc_b.col)
        begin
            oa_r = wrap_step(loc_a.row, decrypt);
            ob_r = wrap_step(loc_b.row, decrypt);
            oa_c = loc_a.col;
            ob_c = loc_b.col;
        end
        else
        begin
            // Rectangle: swap columns.
            oa_r = loc_a.row;
            ob_r = loc_b.row;
            oa_c = loc_b.col;
            ob_c = loc_a.col;
        end
    end

    always_comb
    begin
        if (loc_a.found && loc_b.found)
        begin
            result.not_found = 1'b0;
            result.out_a     = cell_at(square, oa_r, oa_c);
            result.out_b     = cell_at(square, ob_r, ob_c);
        end
        else
        begin
            result.not_found = 1'b1;
            result.out_a     = '0;
            result.out_b     = '0;
        end
    end

endmodule

// ----- src/playfair_digraph_cipher_core.sv -----
// Top level of the Playfair digraph cipher core: stream ports, key registers, pipeline.
//
// Usage:
//   Load the 5x5 key square and the direction through the cfg channel while the
//   core is idle. cfg_index 0 takes cells 0..9, 1 takes cells 10..19, 2 takes
//   cells 20..24 (five bits per cell, cell 0 in the lowest bits, row-major) and
//   3 takes the direction (0 encrypt, 1 decrypt). Other indexes are ignored.
//   cfg_ready is always high, so every cfg transfer is accepted.
//   Feed digraphs on the s_axis side; each one yields exactly one result on the
//   m_axis side carrying both transformed letters and a not_found flag.
// Timing:
//   An input transfer passes an input register, then the lookup logic, then
//   the result register before it shows on m_axis_tvalid. One digraph is taken
//   every cycle while m_axis_tready stays high; the key search and the cell read
//   of one pair fit between those two registers.
// Reset and stalls:
//   rst_n clears both pipeline valid bits and the key registers (all cells A,
//   encrypt). When m_axis_tready drops, the result register holds and the input
//   register still fills once, so s_axis_tready falls only when both are full.
module playfair_digraph_cipher_core
    import pf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [4:0] letter_a, [9:5] letter_b, [10] b_present
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [4:0] out_a, [9:5] out_b, [10] not_found
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDE_W-1:0]    cfg_data
);

    logic [WIDE_W-1:0]   first_ten_reg;
    logic [WIDE_W-1:0]   next_ten_reg;
    logic [NARROW_W-1:0] last_five_reg;
    logic                direction_reg;

    logic                in_valid_reg;
    logic                in_valid_next;
    letter_t             in_a_reg;
    letter_t             in_b_reg;
    logic                in_present_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    pf_result_t          out_data_reg;

    logic                advance;
    logic                in_xfer;
    square_t             square;
    pf_result_t          result;

    // Key configuration: writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_ten_reg <= '0;
            next_ten_reg  <= '0;
            last_five_reg <= '0;
            direction_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIRST_TEN: first_ten_reg <= cfg_data;
                CFG_NEXT_TEN:  next_ten_reg  <= cfg_data;
                CFG_LAST_FIVE: last_five_reg <= cfg_data[NARROW_W-1:0];
                CFG_DIRECTION: direction_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Unpack the three key registers into a flat 25-cell square.
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            square[i]      = first_ten_reg[i * LETTER_W +: LETTER_W];
            square[i + 10] = next_ten_reg[i * LETTER_W +: LETTER_W];
        end
        for (int i = 0; i < 5; i++)
        begin
            square[i + 20] = last_five_reg[i * LETTER_W +: LETTER_W];
        end
    end

    // Pipeline control: advance the result register when it is empty or drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: capture the digraph on each transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_a_reg       <= s_axis_tdata[4:0];
            in_b_reg       <= s_axis_tdata[9:5];
            in_present_reg <= s_axis_tdata[10];
        end
    end

    pf_lookup u_lookup (
        .square    (square),
        .decrypt   (direction_reg),
        .letter_a  (in_a_reg),
        .letter_b  (in_b_reg),
        .b_present (in_present_reg),
        .result    (result)
    );

    // Result register: load when advancing, hold while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg.not_found, out_data_reg.out_b,
                            out_data_reg.out_a};

endmodule
